// File: hdl/e2ep44_pkg.sv
package e2ep44_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_HDR_OFFSET = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DATA_ID    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_LEN    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DELTA  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SRC_MODE   = 3'd5;

  // register reset values
  localparam logic [15:0] HdrOffsetRst = 16'd0;
  localparam logic [31:0] DataIdRst    = 32'd0;
  localparam logic [15:0] MinLenRst    = 16'd16;
  localparam logic [15:0] MaxLenRst    = 16'd4096;
  localparam logic [15:0] MaxDeltaRst  = 16'd1;
  localparam logic        SrcModeRst   = 1'b1;

  // protocol constants
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly    = 32'hC8DF_352F;
  localparam logic [15:0] CounterMax = 16'hFFFF;
  localparam logic [16:0] HdrBytes   = 17'd16;
  localparam logic [16:0] CrcGapLo   = 17'd8;
  localparam logic [16:0] CrcGapHi   = 17'd12;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_OKSOMELOST = 3'd1,
    ST_ERROR      = 3'd2,
    ST_REPEATED   = 3'd3,
    ST_NONEWDATA  = 3'd4,
    ST_WRONGSEQ   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    GEN_OK        = 3'd0,
    GEN_ERROR     = 3'd1,
    GEN_REPEATED  = 3'd2,
    GEN_NONEWDATA = 3'd3,
    GEN_WRONGSEQ  = 3'd4
  } generic_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        no_data;
    logic [27:0] expected_source_id;
    logic        expected_msg_type;
    logic        expected_msg_result;
  } in_item_t;

  typedef struct packed {
    logic        return_code;
    logic [2:0]  check_status;
    logic [2:0]  generic_status;
    logic [27:0] received_source_id;
    logic [15:0] received_counter;
  } out_item_t;

  // captured e2e header
  typedef struct packed {
    logic [15:0] length;
    logic [15:0] counter;
    logic [31:0] data_id;
    logic [31:0] crc;
    logic [31:0] src_word;
  } hdr_t;

  // message view after the current byte
  typedef struct packed {
    logic [15:0] pos;
    logic [31:0] crc;
    hdr_t        hdr;
  } msg_t;

  // one byte of reflected crc-32p4
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // status to generic status
  function automatic logic [2:0] map_generic(input logic rc, input logic [2:0] st);
    generic_e g;
    if (rc) begin
      g = GEN_ERROR;
    end else begin
      case (st) inside
        ST_OK, ST_OKSOMELOST: g = GEN_OK;
        ST_REPEATED:          g = GEN_REPEATED;
        ST_NONEWDATA:         g = GEN_NONEWDATA;
        ST_WRONGSEQ:          g = GEN_WRONGSEQ;
        default:              g = GEN_ERROR;
      endcase
    end
    return g;
  endfunction

endpackage

// File: hdl/e2ep44_stream_if.sv
interface e2ep44_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/e2ep44_accum.sv
module e2ep44_accum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                restart_i,
  input  logic                no_data_i,
  input  logic [7:0]          byte_i,
  input  logic [15:0]         offset_i,
  output e2ep44_pkg::msg_t    msg_o
);

  logic [15:0]       pos_q, pos_d;
  logic [31:0]       crc_q, crc_upd;
  e2ep44_pkg::hdr_t  hdr_q, hdr_upd;

  logic [16:0] off_ext, pos_ext, rel_full;
  logic [3:0]  rel;
  logic        in_gap, in_hdr;

  function automatic logic [31:0] put32(input logic [31:0] w, input logic [1:0] k,
                                        input logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (k)
      2'd0:    r[31:24] = b;
      2'd1:    r[23:16] = b;
      2'd2:    r[15:8]  = b;
      default: r[7:0]   = b;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] put16(input logic [15:0] w, input logic k,
                                        input logic [7:0] b);
    logic [15:0] r;
    r = w;
    if (k) r[7:0] = b;
    else   r[15:8] = b;
    return r;
  endfunction

  // window decode against the header offset
  always_comb begin
    off_ext  = {1'b0, offset_i};
    pos_ext  = {1'b0, pos_q};
    rel_full = pos_ext - off_ext;
    rel      = rel_full[3:0];
    in_gap   = (pos_ext >= off_ext + e2ep44_pkg::CrcGapLo) &&
               (pos_ext < off_ext + e2ep44_pkg::CrcGapHi);
    in_hdr   = (pos_ext >= off_ext) && (pos_ext < off_ext + e2ep44_pkg::HdrBytes);
  end

  // crc and header byte capture
  always_comb begin
    crc_upd = in_gap ? crc_q : e2ep44_pkg::crc_byte(crc_q, byte_i);
    hdr_upd = hdr_q;
    if (in_hdr) begin
      case (rel[3:2])
        2'd0: begin
          if (!rel[1]) hdr_upd.length  = put16(hdr_q.length, rel[0], byte_i);
          else         hdr_upd.counter = put16(hdr_q.counter, rel[0], byte_i);
        end
        2'd1:    hdr_upd.data_id  = put32(hdr_q.data_id, rel[1:0], byte_i);
        2'd2:    hdr_upd.crc      = put32(hdr_q.crc, rel[1:0], byte_i);
        default: hdr_upd.src_word = put32(hdr_q.src_word, rel[1:0], byte_i);
      endcase
    end
    pos_d = (pos_q != e2ep44_pkg::CounterMax) ? pos_q + 16'd1 : pos_q;
  end

  assign msg_o.pos = pos_q;
  assign msg_o.crc = crc_upd;
  assign msg_o.hdr = hdr_upd;

  // message state, restarted after each result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= e2ep44_pkg::CrcInit;
      hdr_q <= '0;
    end else if (step_i) begin
      if (restart_i || no_data_i) begin
        pos_q <= '0;
        crc_q <= e2ep44_pkg::CrcInit;
        hdr_q <= '0;
      end else begin
        pos_q <= pos_d;
        crc_q <= crc_upd;
        hdr_q <= hdr_upd;
      end
    end
  end

endmodule

// File: hdl/e2e_p44m_receive_checker.sv
// E2E profile 44m receive check. Message bytes enter one per transfer on in_i;
// the byte marked last_byte, or a transfer with no_data set, yields one result
// on out_o, other bytes yield none. Throughput is one byte per clock cycle while
// no result waits in a stalled result register. Each byte is held in an input
// register and then goes through a single pass of logic (one crc-32p4 byte step,
// header capture, field compares and counter delta) into the result register.
// A stalled result register holds only the byte that carries a result; input
// stalls only while that result waits. The user must write configuration
// through cfg_we_i/cfg_idx_i/cfg_data_i only while idle; it is not enforced.
module e2e_p44m_receive_checker (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [e2ep44_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [e2ep44_pkg::CfgDataW-1:0]        cfg_data_i,
  e2ep44_stream_if.sink                          in_i,
  e2ep44_stream_if.source                        out_o
);

  // configuration registers
  logic [15:0] hdr_offset_q, min_len_q, max_len_q, max_delta_q;
  logic [31:0] data_id_q;
  logic        src_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_offset_q <= e2ep44_pkg::HdrOffsetRst;
      data_id_q    <= e2ep44_pkg::DataIdRst;
      min_len_q    <= e2ep44_pkg::MinLenRst;
      max_len_q    <= e2ep44_pkg::MaxLenRst;
      max_delta_q  <= e2ep44_pkg::MaxDeltaRst;
      src_mode_q   <= e2ep44_pkg::SrcModeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        e2ep44_pkg::CFG_HDR_OFFSET: hdr_offset_q <= cfg_data_i[15:0];
        e2ep44_pkg::CFG_DATA_ID:    data_id_q    <= cfg_data_i;
        e2ep44_pkg::CFG_MIN_LEN:    min_len_q    <= cfg_data_i[15:0];
        e2ep44_pkg::CFG_MAX_LEN:    max_len_q    <= cfg_data_i[15:0];
        e2ep44_pkg::CFG_MAX_DELTA:  max_delta_q  <= cfg_data_i[15:0];
        e2ep44_pkg::CFG_SRC_MODE:   src_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register and handshake
  logic                  s1_valid_q;
  e2ep44_pkg::in_item_t  s1_item_q;
  logic                  s1_has_res, s1_adv, out_free, in_ready, in_xfer;

  logic                  out_valid_q;
  e2ep44_pkg::out_item_t out_item_q, res;

  assign s1_has_res = s1_item_q.no_data || s1_item_q.last_byte;
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!s1_has_res || out_free);
  assign in_ready   = !s1_valid_q || s1_adv;
  assign in_xfer    = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) s1_item_q <= in_i.payload;
  end

  // running crc, byte position and header capture
  e2ep44_pkg::msg_t msg;

  e2ep44_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_adv),
    .restart_i (s1_item_q.last_byte),
    .no_data_i (s1_item_q.no_data),
    .byte_i    (s1_item_q.data_byte),
    .offset_i  (hdr_offset_q),
    .msg_o     (msg)
  );

  // message check and counter classification
  logic [15:0]         last_cnt_q, last_cnt_d;
  e2ep44_pkg::status_e last_st_q, last_st_d;

  logic [16:0] length;
  logic [15:0] delta;
  logic        len_bad, too_short, fields_ok, rx_type, rx_res;
  logic [27:0] rx_src;

  always_comb begin
    length    = {1'b0, msg.pos} + 17'd1;
    len_bad   = (length < {1'b0, min_len_q}) || (length > {1'b0, max_len_q});
    too_short = length < ({1'b0, hdr_offset_q} + e2ep44_pkg::HdrBytes);
    rx_src    = msg.hdr.src_word[27:0];
    rx_type   = msg.hdr.src_word[31:30] != 2'd0;
    rx_res    = msg.hdr.src_word[29:28] != 2'd0;
    fields_ok = ((msg.crc ^ e2ep44_pkg::CrcInit) == msg.hdr.crc) &&
                (msg.hdr.data_id == data_id_q) &&
                ({1'b0, msg.hdr.length} == length) &&
                (rx_type == s1_item_q.expected_msg_type) &&
                (rx_res == s1_item_q.expected_msg_result) &&
                (!src_mode_q || (rx_src == s1_item_q.expected_source_id));
    delta     = msg.hdr.counter - last_cnt_q;

    last_st_d  = last_st_q;
    last_cnt_d = last_cnt_q;
    res        = '0;
    if (s1_item_q.no_data) begin
      last_st_d          = e2ep44_pkg::ST_NONEWDATA;
      res.check_status   = e2ep44_pkg::ST_NONEWDATA;
      res.generic_status = e2ep44_pkg::GEN_NONEWDATA;
    end else begin
      if (!len_bad) begin
        if (too_short || !fields_ok) begin
          last_st_d = e2ep44_pkg::ST_ERROR;
        end else begin
          if (delta > max_delta_q)  last_st_d = e2ep44_pkg::ST_WRONGSEQ;
          else if (delta == 16'd0)  last_st_d = e2ep44_pkg::ST_REPEATED;
          else if (delta == 16'd1)  last_st_d = e2ep44_pkg::ST_OK;
          else                      last_st_d = e2ep44_pkg::ST_OKSOMELOST;
          last_cnt_d = msg.hdr.counter;
        end
      end
      res.return_code        = len_bad;
      res.check_status       = last_st_d;
      res.generic_status     = e2ep44_pkg::map_generic(len_bad, last_st_d);
      res.received_source_id = rx_src;
      res.received_counter   = msg.hdr.counter;
    end
  end

  // stored counter and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cnt_q <= e2ep44_pkg::CounterMax;
      last_st_q  <= e2ep44_pkg::ST_ERROR;
    end else if (s1_adv && s1_has_res) begin
      last_cnt_q <= last_cnt_d;
      last_st_q  <= last_st_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_has_res) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_has_res) out_item_q <= res;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule

// File: hdl/e2ep44_checker.sv
module e2ep44_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input e2ep44_pkg::out_item_t out_item_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result changed while stalled");

  // input stalls only behind a waiting result
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a waiting result");

  // length error maps to generic error
  a_rc_generic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.return_code |->
      out_item_i.generic_status == e2ep44_pkg::GEN_ERROR)
    else $error("return code without generic error");

  // status mapping when length is in range
  a_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.return_code |->
      out_item_i.generic_status ==
        e2ep44_pkg::map_generic(1'b0, out_item_i.check_status))
    else $error("generic status does not match status");

  // no new data reports empty fields
  a_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_item_i.return_code &&
    out_item_i.check_status == e2ep44_pkg::ST_NONEWDATA |->
      out_item_i.received_source_id == 28'd0 && out_item_i.received_counter == 16'd0)
    else $error("no new data result carries header fields");

endmodule

bind e2e_p44m_receive_checker e2ep44_checker u_e2ep44_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);

// File: tb/sv/tb_e2e_p44m_receive_checker.sv
module tb_e2e_p44m_receive_checker;
  import e2ep44_pkg::*;

  localparam int unsigned ClkHalf   = 6;
  localparam int unsigned LimitTime = 12 * 1_000_000;

  // kinds of damage applied to a generated message
  typedef enum int {
    MSG_CLEAN,
    MSG_BAD_CRC,
    MSG_BAD_ID,
    MSG_BAD_LEN,
    MSG_BAD_TYPE,
    MSG_BAD_RES,
    MSG_BAD_SRC,
    MSG_TRUNCATED,
    MSG_ABORTED
  } msg_flaw_e;

  logic clk_i = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  e2ep44_stream_if #(.payload_t(in_item_t))  in_if ();
  e2ep44_stream_if #(.payload_t(out_item_t)) out_if ();

  e2e_p44m_receive_checker DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // pending message bytes and expected check verdicts
  in_item_t  byte_queue [$];
  out_item_t verdict_queue [$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned errors;
  int unsigned mismatches;
  logic        in_taken;
  logic [15:0] tx_counter;

  // configuration shadow
  logic [15:0] cfg_off;
  logic [31:0] cfg_did;
  logic [15:0] cfg_min;
  logic [15:0] cfg_max;
  logic [15:0] cfg_delta;
  logic        cfg_mode;

  // receive-side state of the checker
  logic [15:0] rx_pos;
  logic [31:0] rx_crc;
  logic [7:0]  rx_hdr [16];
  logic [15:0] seq_last_cnt;
  status_e     seq_last_st;

  // reflected crc-32p4, one byte
  function automatic logic [31:0] crc_p4_next(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'h0, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    return r;
  endfunction

  function automatic generic_e to_generic(input logic rc, input status_e st);
    if (rc) return GEN_ERROR;
    case (st)
      ST_OK, ST_OKSOMELOST: return GEN_OK;
      ST_REPEATED:          return GEN_REPEATED;
      ST_NONEWDATA:         return GEN_NONEWDATA;
      ST_WRONGSEQ:          return GEN_WRONGSEQ;
      default:              return GEN_ERROR;
    endcase
  endfunction

  function automatic void restart_msg();
    rx_pos = '0;
    rx_crc = CrcInit;
    foreach (rx_hdr[j]) rx_hdr[j] = 8'h00;
  endfunction

  // one received byte; returns 1 when it produces a verdict
  function automatic bit e2e_check_step(input in_item_t it, output out_item_t res);
    int unsigned pos;
    int unsigned off;
    int unsigned len;
    logic [15:0] h_len;
    logic [15:0] h_cnt;
    logic [15:0] dlt;
    logic [31:0] h_id;
    logic [31:0] h_crc;
    logic [31:0] h_src;
    logic        rc;
    bit          good;
    res = '0;
    rc  = 1'b0;
    if (it.no_data) begin
      restart_msg();
      seq_last_st        = ST_NONEWDATA;
      res.check_status   = ST_NONEWDATA;
      res.generic_status = GEN_NONEWDATA;
      return 1'b1;
    end
    pos = rx_pos;
    off = cfg_off;
    // the crc field itself is left out of the crc
    if (pos < off + 8 || pos >= off + 12) rx_crc = crc_p4_next(rx_crc, it.data_byte);
    if (pos >= off && pos < off + 16) rx_hdr[pos - off] = it.data_byte;
    if (rx_pos != CounterMax) rx_pos = rx_pos + 16'd1;
    if (!it.last_byte) return 1'b0;

    h_len = {rx_hdr[0], rx_hdr[1]};
    h_cnt = {rx_hdr[2], rx_hdr[3]};
    h_id  = {rx_hdr[4], rx_hdr[5], rx_hdr[6], rx_hdr[7]};
    h_crc = {rx_hdr[8], rx_hdr[9], rx_hdr[10], rx_hdr[11]};
    h_src = {rx_hdr[12], rx_hdr[13], rx_hdr[14], rx_hdr[15]};
    len   = pos + 1;

    if (len < cfg_min || len > cfg_max) begin
      rc = 1'b1;
    end else if (len < off + 16) begin
      seq_last_st = ST_ERROR;
    end else begin
      good = ((rx_crc ^ CrcInit) == h_crc) && (h_id == cfg_did) && (h_len == len) &&
             ((|h_src[31:30]) == it.expected_msg_type) &&
             ((|h_src[29:28]) == it.expected_msg_result) &&
             (!cfg_mode || h_src[27:0] == it.expected_source_id);
      if (!good) begin
        seq_last_st = ST_ERROR;
      end else begin
        dlt = h_cnt - seq_last_cnt;
        if (dlt > cfg_delta)  seq_last_st = ST_WRONGSEQ;
        else if (dlt == 16'd0) seq_last_st = ST_REPEATED;
        else if (dlt == 16'd1) seq_last_st = ST_OK;
        else                   seq_last_st = ST_OKSOMELOST;
        seq_last_cnt = h_cnt;
      end
    end
    res.return_code        = rc;
    res.check_status       = seq_last_st;
    res.generic_status     = to_generic(rc, seq_last_st);
    res.received_source_id = h_src[27:0];
    res.received_counter   = h_cnt;
    restart_msg();
    return 1'b1;
  endfunction

  // driver: new byte or idle at the falling edge
  always @(negedge clk_i) begin
    if (!rst_n) begin
      in_if.valid  <= 1'b0;
      out_if.ready <= 1'b0;
    end else begin
      if (!in_if.valid || in_taken) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_if.valid   <= 1'b1;
          in_if.payload <= byte_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: check result transfers, predict on input transfers
  always @(posedge clk_i or negedge rst_n) begin : monitor
    out_item_t want;
    out_item_t got;
    out_item_t res;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (verdict_queue.size() == 0) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: rc %0d st %0d gen %0d src %h cnt %h",
                     got.return_code, got.check_status, got.generic_status,
                     got.received_source_id, got.received_counter);
        end else begin
          want = verdict_queue.pop_front();
          if (got.return_code !== want.return_code ||
              got.check_status !== want.check_status ||
              got.generic_status !== want.generic_status ||
              got.received_source_id !== want.received_source_id ||
              got.received_counter !== want.received_counter) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch (exp/got): rc %0d/%0d st %0d/%0d gen %0d/%0d src %h/%h cnt %h/%h",
                       want.return_code, got.return_code, want.check_status, got.check_status,
                       want.generic_status, got.generic_status, want.received_source_id,
                       got.received_source_id, want.received_counter, got.received_counter);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (e2e_check_step(in_if.payload, res)) verdict_queue.push_back(res);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      CFG_HDR_OFFSET: cfg_off   = val[15:0];
      CFG_DATA_ID:    cfg_did   = val;
      CFG_MIN_LEN:    cfg_min   = val[15:0];
      CFG_MAX_LEN:    cfg_max   = val[15:0];
      CFG_MAX_DELTA:  cfg_delta = val[15:0];
      CFG_SRC_MODE:   cfg_mode  = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // upper data bits beyond each register are junk
  task automatic apply_cfg(input logic [15:0] off, input logic [31:0] did,
                           input logic [15:0] minl, input logic [15:0] maxl,
                           input logic [15:0] dlt, input logic mode);
    write_reg(CFG_HDR_OFFSET, {16'($urandom), off});
    write_reg(CFG_DATA_ID, did);
    write_reg(CFG_MIN_LEN, {16'($urandom), minl});
    write_reg(CFG_MAX_LEN, {16'($urandom), maxl});
    write_reg(CFG_MAX_DELTA, {16'($urandom), dlt});
    write_reg(CFG_SRC_MODE, {31'($urandom), mode});
  endtask

  // build one message for the current offset and data id, then queue its bytes
  task automatic push_msg(input int unsigned len, input logic [15:0] cnt, input logic typ,
                          input logic res, input logic [27:0] src, input msg_flaw_e flaw);
    logic [7:0]  body [$];
    logic [31:0] crc;
    logic [31:0] did;
    logic [15:0] lenf;
    logic [1:0]  tbits;
    logic [1:0]  rbits;
    logic [27:0] esrc;
    int unsigned off;
    int unsigned stop;
    int unsigned i;
    in_item_t    it;
    off = cfg_off;
    for (i = 0; i < len; i++) body.push_back(8'($urandom));
    if (len >= off + 16) begin
      lenf  = len[15:0];
      did   = cfg_did;
      tbits = typ ? 2'($urandom_range(1, 3)) : 2'b00;
      rbits = res ? 2'($urandom_range(1, 3)) : 2'b00;
      if (flaw == MSG_BAD_LEN) lenf = lenf ^ 16'($urandom_range(1, 65535));
      if (flaw == MSG_BAD_ID)  did  = did ^ ($urandom | 32'h1);
      body[off]      = lenf[15:8];
      body[off + 1]  = lenf[7:0];
      body[off + 2]  = cnt[15:8];
      body[off + 3]  = cnt[7:0];
      body[off + 4]  = did[31:24];
      body[off + 5]  = did[23:16];
      body[off + 6]  = did[15:8];
      body[off + 7]  = did[7:0];
      body[off + 12] = {tbits, rbits, src[27:24]};
      body[off + 13] = src[23:16];
      body[off + 14] = src[15:8];
      body[off + 15] = src[7:0];
      crc = CrcInit;
      for (i = 0; i < len; i++)
        if (i < off + 8 || i >= off + 12) crc = crc_p4_next(crc, body[i]);
      crc = crc ^ CrcInit;
      if (flaw == MSG_BAD_CRC) crc = crc ^ (32'h1 << $urandom_range(31));
      body[off + 8]  = crc[31:24];
      body[off + 9]  = crc[23:16];
      body[off + 10] = crc[15:8];
      body[off + 11] = crc[7:0];
    end
    esrc = (flaw == MSG_BAD_SRC) ? (src ^ 28'($urandom_range(1, 28'hFFFFFFF))) : src;
    stop = len;
    if (flaw == MSG_TRUNCATED && len > 1) stop = $urandom_range(1, len - 1);
    if (flaw == MSG_ABORTED) stop = $urandom_range(0, len - 1);
    for (i = 0; i < stop; i++) begin
      it.data_byte = body[i];
      it.no_data   = 1'b0;
      it.last_byte = (i == stop - 1) && (flaw != MSG_ABORTED);
      if (it.last_byte) begin
        it.expected_source_id  = esrc;
        it.expected_msg_type   = typ ^ (flaw == MSG_BAD_TYPE);
        it.expected_msg_result = res ^ (flaw == MSG_BAD_RES);
      end else begin
        it.expected_source_id  = 28'($urandom);
        it.expected_msg_type   = 1'($urandom);
        it.expected_msg_result = 1'($urandom);
      end
      byte_queue.push_back(it);
    end
    // an aborted message is dropped by a no-data call
    if (flaw == MSG_ABORTED) begin
      it.data_byte           = 8'($urandom);
      it.last_byte           = 1'($urandom);
      it.no_data             = 1'b1;
      it.expected_source_id  = 28'($urandom);
      it.expected_msg_type   = 1'($urandom);
      it.expected_msg_result = 1'($urandom);
      byte_queue.push_back(it);
    end
  endtask

  // random bytes, random ends and no-data calls, always closed by a last byte
  task automatic push_noise(input int unsigned n);
    in_item_t    it;
    int unsigned i;
    for (i = 0; i < n; i++) begin
      it.data_byte           = 8'($urandom);
      it.last_byte           = ($urandom_range(7) == 0) || (i == n - 1);
      it.no_data             = ($urandom_range(15) == 0);
      it.expected_source_id  = 28'($urandom);
      it.expected_msg_type   = 1'($urandom);
      it.expected_msg_result = 1'($urandom);
      byte_queue.push_back(it);
    end
  endtask

  // next sender counter: mostly in order, some repeats, gaps and jumps
  function automatic logic [15:0] next_counter();
    int unsigned r;
    int unsigned hi;
    r  = $urandom_range(99);
    hi = (cfg_delta >= 16'hFFFE) ? 65535 : cfg_delta + 1;
    if (r < 60)      tx_counter = tx_counter + 16'd1;
    else if (r < 70) tx_counter = tx_counter;
    else if (r < 85) tx_counter = tx_counter + 16'($urandom_range(2, hi));
    else             tx_counter = tx_counter + 16'($urandom);
    return tx_counter;
  endfunction

  task automatic drain();
    while (byte_queue.size() != 0 || in_if.valid) @(posedge clk_i);
    while (verdict_queue.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic run_random(input int budget);
    int unsigned k;
    int unsigned len;
    while (budget > 0) begin
      k   = $urandom_range(99);
      len = cfg_off + 16 +
            (($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6));
      if (k < 62) begin
        push_msg(len, next_counter(), 1'($urandom), 1'($urandom), 28'($urandom), MSG_CLEAN);
      end else if (k < 86) begin
        push_msg(len, next_counter(), 1'($urandom), 1'($urandom), 28'($urandom),
                 msg_flaw_e'($urandom_range(MSG_BAD_CRC, MSG_ABORTED)));
      end else begin
        len = $urandom_range(4, 30);
        push_noise(len);
      end
      budget -= len;
    end
  endtask

  initial begin : main
    in_item_t    nd;
    logic [15:0] off_v;
    logic [15:0] min_v;
    logic [15:0] max_v;
    logic [15:0] dlt_v;
    int unsigned ph;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_data       = '0;
    rst_n          = 1'b0;
    errors         = 0;
    mismatches     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    tx_counter     = 16'hFFFF;
    cfg_off        = HdrOffsetRst;
    cfg_did        = DataIdRst;
    cfg_min        = MinLenRst;
    cfg_max        = MaxLenRst;
    cfg_delta      = MaxDeltaRst;
    cfg_mode       = SrcModeRst;
    restart_msg();
    seq_last_cnt   = CounterMax;
    seq_last_st    = ST_ERROR;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, counter classes, short message, abort, bad crc
    nd = '0;
    nd.no_data = 1'b1;
    nd.data_byte = 8'hFF;
    nd.last_byte = 1'b1;
    byte_queue.push_back(nd);
    push_msg(16, 16'h0000, 1'b1, 1'b1, 28'hFFFFFFF, MSG_CLEAN);
    push_msg(16, 16'h0000, 1'b0, 1'b0, 28'h0000000, MSG_CLEAN);
    push_msg(16, 16'h0005, 1'b1, 1'b0, 28'h5A5A5A5, MSG_CLEAN);
    push_msg(10, 16'h0006, 1'b0, 1'b1, 28'h1234567, MSG_CLEAN);
    push_msg(16, 16'h0006, 1'b0, 1'b0, 28'h0000001, MSG_ABORTED);
    push_msg(16, 16'h0006, 1'b0, 1'b0, 28'h0000001, MSG_BAD_CRC);
    drain();

    // header at the highest offset, length below the range
    apply_cfg(16'd65519, 32'hFFFF_FFFF, 16'd65535, 16'd65535, 16'hFFFF, 1'b0);
    push_msg(40, 16'hFFFF, 1'b1, 1'b0, 28'($urandom), MSG_CLEAN);
    push_msg(16, 16'h0000, 1'b0, 1'b1, 28'($urandom), MSG_CLEAN);
    drain();
    // in range but shorter than the header end
    write_reg(CFG_MIN_LEN, 32'd0);
    push_msg(17, 16'h0001, 1'b0, 1'b0, 28'h0, MSG_CLEAN);
    drain();
    // nothing fits under a zero maximum
    apply_cfg(16'd0, 32'h0, 16'd0, 16'd0, 16'd0, 1'b1);
    push_msg(16, 16'h0002, 1'b0, 1'b0, 28'h0, MSG_CLEAN);
    drain();

    // random phases across idling modes and settings
    for (ph = 0; ph < 8; ph++) begin
      send_idle_pct  = (ph % 4 == 1) ? 67 : (ph % 4 == 3) ? 16 : 0;
      recv_stall_pct = (ph % 4 == 2) ? 67 : (ph % 4 == 3) ? 16 : 0;
      case (ph)
        0: apply_cfg(16'd0, $urandom, 16'd16, 16'd4096, 16'd1, 1'b1);
        1: apply_cfg(16'd3, 32'hFFFF_FFFF, 16'd0, 16'd65535, 16'd0, 1'b0);
        2: apply_cfg(16'd5, 32'h0, 16'd23, 16'd30, 16'hFFFF, 1'b1);
        3: apply_cfg(16'd2, $urandom, 16'd18, 16'd26, 16'd3, 1'b0);
        default: begin
          off_v = 16'($urandom_range(0, 6));
          min_v = 16'($urandom_range(0, off_v + 18));
          max_v = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(off_v + 20, off_v + 40));
          dlt_v = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 4));
          apply_cfg(off_v, $urandom, min_v, max_v, dlt_v, 1'($urandom));
        end
      endcase
      run_random(190);
      drain();
    end

    if (errors == 0) begin
      $display("tb_e2e_p44m_receive_checker: done, clean");
    end else begin
      $display("tb_e2e_p44m_receive_checker: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #(LimitTime);
    $display("tb_e2e_p44m_receive_checker: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
hdl/e2ep44_pkg.sv
hdl/e2ep44_stream_if.sv
hdl/e2ep44_accum.sv
hdl/e2e_p44m_receive_checker.sv
hdl/e2ep44_checker.sv
tb/sv/tb_e2e_p44m_receive_checker.sv
